// ----- rtl/gradient_band_blend_weights_macros.svh -----
// Assertion macros shared by the checker.
`ifndef GRADIENT_BAND_BLEND_WEIGHTS_MACROS_SVH
`define GRADIENT_BAND_BLEND_WEIGHTS_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define GBBW_AST_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gbbw check failed");

// Next-cycle implication.
`define GBBW_AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gbbw check failed");

`endif

// ----- rtl/gbbw_pkg.sv -----
// Types and constants shared by the blend weight block.
package gbbw_pkg;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_SAMPLE_COUNT = 1'b0;
	localparam logic REG_CENTER_EN    = 1'b1;

	localparam int D_W   = 17;   // reduced coordinate difference
	localparam int P_W   = 34;   // one product
	localparam int S_W   = 36;   // len, proj, num
	localparam int DV_W  = 36;   // divisor and remainder
	localparam int NUM_W = 34;   // bits shifted into the divider
	localparam int W_W   = 17;   // raw weight, 0..65536
	localparam int Q_W   = 17;   // kept quotient bits
	localparam int SUM_W = 22;   // sum of up to 33 raw weights
	localparam int STP_W = 6;

	localparam logic [W_W-1:0] ONE_Q16 = 17'h10000;
	localparam logic [15:0]    W_MAX   = 16'hFFFF;
	localparam logic [STP_W-1:0] PAIR_STEPS = 6'd16;
	localparam logic [STP_W-1:0] NORM_STEPS = 6'd34;

	typedef struct packed {
		logic              start;
		logic [DV_W-1:0]   rem;
		logic [NUM_W-1:0]  bits;
		logic [STP_W-1:0]  steps;
		logic [DV_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic [2:0]     idx;
		logic           ctr;
		logic [W_W-1:0] w;
	} ent_t;

endpackage

// ----- rtl/gradient_band_blend_weights.sv -----
// Top level: gradient band blend weights over stored 2D sample positions.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  in      | into      | in_valid/in_stall  | operation, sample_slot, coord_x, coord_y
//  out     | out of    | out_valid/out_stall| sample_index, is_center, weight,
//          |           |                    | is_largest, no_weights, last_result
//  cfg     | into      | cfg_we             | cfg_index, cfg_data
//
// A query walks (n+c) anchors by up to (n+c) pairs, each dividing pair in the shared
// serial divider, then divides again to normalize each kept weight and emits the
// results. No clearing pass after reset.
// in_stall is high for the whole query; the output register holds while out_stall.
module gradient_band_blend_weights #(
	parameter int MAX_SAMPLES = 8,
	parameter int COORD_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         operation,
	input  logic [2:0]                   sample_slot,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   sample_index,
	output logic                         is_center,
	output logic [15:0]                  weight,
	output logic                         is_largest,
	output logic                         no_weights,
	output logic                         last_result,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [3:0]                   cfg_data
);
	import gbbw_pkg::*;

	localparam int AW     = $clog2(MAX_SAMPLES);
	localparam int CW     = $clog2(MAX_SAMPLES + 1);
	localparam int RDEPTH = MAX_SAMPLES + 1;
	localparam int RAW    = $clog2(RDEPTH);
	localparam int KW     = $clog2(MAX_SAMPLES + 2);
	localparam int DSHIFT = (COORD_BITS > 16) ? (COORD_BITS - 16) : 0;
	localparam int PW     = 2 * COORD_BITS;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ONE  = 4'd1;   // single fixed result
	localparam logic [3:0] S_ANC  = 4'd2;   // read anchor position
	localparam logic [3:0] S_ALD  = 4'd3;   // load anchor
	localparam logic [3:0] S_PRD  = 4'd4;   // read partner
	localparam logic [3:0] S_PDF  = 4'd5;   // differences
	localparam logic [3:0] S_PMU  = 4'd6;   // products
	localparam logic [3:0] S_PLN  = 4'd7;   // len, proj
	localparam logic [3:0] S_PNM  = 4'd8;   // num and pair decision
	localparam logic [3:0] S_PDV  = 4'd9;   // wait for pair quotient
	localparam logic [3:0] S_AEND = 4'd10;  // store anchor weight
	localparam logic [3:0] S_NRD  = 4'd11;  // read raw weight
	localparam logic [3:0] S_NST  = 4'd12;  // start normalize
	localparam logic [3:0] S_NDW  = 4'd13;  // write back normalized
	localparam logic [3:0] S_ERD  = 4'd14;  // read for emit
	localparam logic [3:0] S_EOUT = 4'd15;  // emit

	logic [3:0] st_q;

	// configuration
	logic [3:0] sample_count_q;
	logic       center_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= 4'd1;
			center_en_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_COUNT: sample_count_q <= cfg_data;
				REG_CENTER_EN:    center_en_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [CW-1:0] n_c;
	always_comb begin
		if (32'(sample_count_q) > MAX_SAMPLES) n_c = CW'(MAX_SAMPLES);
		else n_c = CW'(sample_count_q);
	end

	logic in_acc;
	assign in_stall = (st_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// sample position memory {x, y}
	logic [5:0]    slot_ext;
	logic          pos_we;
	logic [AW-1:0] pos_raddr;
	logic [PW-1:0] pos_rdata;
	logic [CW-1:0] ai_q, j_q;

	assign slot_ext = {3'b000, sample_slot};
	assign pos_we   = in_acc && (operation == OP_WRITE) && (32'(slot_ext) < MAX_SAMPLES);
	assign pos_raddr = (st_q == S_ANC) ? ai_q[AW-1:0] : j_q[AW-1:0];

	gbbw_ram #(.WIDTH(PW), .DEPTH(MAX_SAMPLES)) u_pos (
		.clk   (clk),
		.we    (pos_we),
		.waddr (slot_ext[AW-1:0]),
		.wdata ({coord_x, coord_y}),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	// raw and normalized weight memory
	logic [KW-1:0] cnt_q, k_q, bestk_q;
	logic          ent_we;
	logic [RAW-1:0] ent_waddr;
	ent_t          ent_wdata, ent_rd;

	gbbw_ram #(.WIDTH($bits(ent_t)), .DEPTH(RDEPTH)) u_ent (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (k_q[RAW-1:0]),
		.rdata (ent_rd)
	);

	// shared divider
	div_req_t        dreq;
	logic            ddone;
	logic [Q_W-1:0]  dquot;

	gbbw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (ddone),
		.quot   (dquot)
	);

	// query context
	logic [CW-1:0]              n_q;
	logic                       cen_q;
	logic                       single_q;
	logic signed [COORD_BITS-1:0] px_q, py_q, ax_q, ay_q;
	logic                       anc_ctr_q, org_q, drop_q;
	logic [W_W-1:0]             mw_q;
	logic [SUM_W-1:0]           sum_q;
	logic [15:0]                best_q;
	ent_t                       ent_q;

	// pair datapath
	logic signed [D_W-1:0] d1x_q, d1y_q, d2x_q, d2y_q;
	logic signed [P_W-1:0] sqx_q, sqy_q, prx_q, pry_q;
	logic signed [S_W-1:0] len_q, proj_q;
	logic signed [S_W-1:0] num_c;

	logic signed [COORD_BITS-1:0] bx_c, by_c;
	logic signed [COORD_BITS:0]   e1x, e1y, e2x, e2y;
	logic signed [COORD_BITS:0]   r1x, r1y, r2x, r2y;

	assign bx_c = org_q ? '0 : pos_rdata[PW-1:COORD_BITS];
	assign by_c = org_q ? '0 : pos_rdata[COORD_BITS-1:0];
	assign e1x  = (COORD_BITS+1)'(ax_q) - (COORD_BITS+1)'(px_q);
	assign e1y  = (COORD_BITS+1)'(ay_q) - (COORD_BITS+1)'(py_q);
	assign e2x  = (COORD_BITS+1)'(ax_q) - (COORD_BITS+1)'(bx_c);
	assign e2y  = (COORD_BITS+1)'(ay_q) - (COORD_BITS+1)'(by_c);
	// floor toward minus infinity for wide coordinates
	assign r1x  = e1x >>> DSHIFT;
	assign r1y  = e1y >>> DSHIFT;
	assign r2x  = e2x >>> DSHIFT;
	assign r2y  = e2y >>> DSHIFT;
	assign num_c = len_q - proj_q;

	// kept-weight count after the current anchor closes
	logic [KW-1:0] cnt_nx;
	logic          keep;
	assign keep   = !drop_q && (mw_q != '0);
	assign cnt_nx = cnt_q + KW'(keep);

	// normalize numerator: w * 2^16 + sum / 2
	logic [NUM_W-1:0] nnum;
	assign nnum = NUM_W'({ent_rd.w, 16'h0000}) + NUM_W'(sum_q >> 1);

	logic out_free;
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		dreq         = '0;
		dreq.start   = 1'b0;
		ent_we       = 1'b0;
		ent_waddr    = cnt_q[RAW-1:0];
		ent_wdata    = '0;
		if (st_q == S_PNM) begin
			dreq.rem     = DV_W'(num_c);
			dreq.steps   = PAIR_STEPS;
			dreq.divisor = DV_W'(len_q);
			dreq.start   = (len_q != '0) && (num_c > 0) && (num_c < len_q);
		end else if (st_q == S_NST) begin
			dreq.bits    = nnum;
			dreq.steps   = NORM_STEPS;
			dreq.divisor = DV_W'(sum_q);
			dreq.start   = 1'b1;
		end
		if (st_q == S_AEND) begin
			ent_we        = keep;
			ent_wdata.idx = anc_ctr_q ? 3'd0 : 3'(ai_q);
			ent_wdata.ctr = anc_ctr_q;
			ent_wdata.w   = mw_q;
		end else if (st_q == S_NDW && ddone) begin
			ent_we        = 1'b1;
			ent_waddr     = k_q[RAW-1:0];
			ent_wdata.idx = ent_q.idx;
			ent_wdata.ctr = ent_q.ctr;
			ent_wdata.w   = (dquot > Q_W'(W_MAX)) ? W_W'(W_MAX) : dquot;
		end
	end

	logic [15:0] nw_c;
	assign nw_c = (dquot > Q_W'(W_MAX)) ? W_MAX : dquot[15:0];

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in_acc && operation == OP_QUERY) begin
						if (n_c == CW'(1) && !center_en_q) st_q <= S_ONE;
						else if (n_c != '0) st_q <= S_ANC;
						else if (center_en_q) st_q <= S_PRD;
						else st_q <= S_ONE;
					end
				end
				S_ONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						st_q      <= S_IDLE;
					end
				end
				S_ANC:  st_q <= S_ALD;
				S_ALD:  st_q <= S_PRD;
				S_PRD: begin
					if (j_q < n_q || (cen_q && !anc_ctr_q)) st_q <= S_PDF;
					else st_q <= S_AEND;
				end
				S_PDF:  st_q <= S_PMU;
				S_PMU:  st_q <= S_PLN;
				S_PLN:  st_q <= S_PNM;
				S_PNM: begin
					if (dreq.start) st_q <= S_PDV;
					else if (org_q) st_q <= S_AEND;
					else st_q <= S_PRD;
				end
				S_PDV: begin
					if (ddone) st_q <= org_q ? S_AEND : S_PRD;
				end
				S_AEND: begin
					if (!anc_ctr_q && 32'(ai_q) + 1 < 32'(n_q)) st_q <= S_ANC;
					else if (!anc_ctr_q && cen_q) st_q <= S_PRD;
					else if (cnt_nx == '0) st_q <= S_ONE;
					else st_q <= S_NRD;
				end
				S_NRD:  st_q <= S_NST;
				S_NST:  st_q <= S_NDW;
				S_NDW: begin
					if (ddone) st_q <= (k_q + 1'b1 < cnt_q) ? S_NRD : S_ERD;
				end
				S_ERD:  st_q <= S_EOUT;
				S_EOUT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						st_q      <= (k_q + 1'b1 == cnt_q) ? S_IDLE : S_ERD;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				n_q       <= n_c;
				cen_q     <= center_en_q;
				single_q  <= (n_c == CW'(1)) && !center_en_q;
				px_q      <= coord_x;
				py_q      <= coord_y;
				ai_q      <= '0;
				j_q       <= '0;
				cnt_q     <= '0;
				sum_q     <= '0;
				org_q     <= 1'b0;
				drop_q    <= 1'b0;
				mw_q      <= ONE_Q16;
				// no samples in use: go straight to the center anchor
				anc_ctr_q <= (n_c == '0);
				ax_q      <= '0;
				ay_q      <= '0;
			end
			S_ALD: begin
				ax_q   <= pos_rdata[PW-1:COORD_BITS];
				ay_q   <= pos_rdata[COORD_BITS-1:0];
				mw_q   <= ONE_Q16;
				drop_q <= 1'b0;
				j_q    <= '0;
			end
			S_PRD: begin
				org_q <= !(j_q < n_q);
			end
			S_PDF: begin
				d1x_q <= D_W'(r1x);
				d1y_q <= D_W'(r1y);
				d2x_q <= D_W'(r2x);
				d2y_q <= D_W'(r2y);
			end
			S_PMU: begin
				sqx_q <= d2x_q * d2x_q;
				sqy_q <= d2y_q * d2y_q;
				prx_q <= d1x_q * d2x_q;
				pry_q <= d1y_q * d2y_q;
			end
			S_PLN: begin
				len_q  <= S_W'(sqx_q) + S_W'(sqy_q);
				proj_q <= S_W'(prx_q) + S_W'(pry_q);
			end
			S_PNM: begin
				if (!org_q) j_q <= j_q + 1'b1;
				if (len_q == '0) begin
					if (org_q) drop_q <= 1'b1;
				end else if (num_c <= 0) begin
					mw_q <= '0;
				end
			end
			S_PDV: begin
				if (ddone && dquot < mw_q) mw_q <= dquot;
			end
			S_AEND: begin
				if (keep) sum_q <= sum_q + SUM_W'(mw_q);
				cnt_q  <= cnt_nx;
				k_q    <= '0;
				if (!anc_ctr_q) begin
					ai_q <= ai_q + 1'b1;
					if (!(32'(ai_q) + 1 < 32'(n_q)) && cen_q) begin
						anc_ctr_q <= 1'b1;
						ax_q      <= '0;
						ay_q      <= '0;
						mw_q      <= ONE_Q16;
						drop_q    <= 1'b0;
						j_q       <= '0;
					end
				end
			end
			S_NST: begin
				ent_q <= ent_rd;
			end
			S_NDW: begin
				if (ddone) begin
					if (k_q == '0 || nw_c > best_q) begin
						best_q  <= nw_c;
						bestk_q <= k_q;
					end
					k_q <= (k_q + 1'b1 < cnt_q) ? k_q + 1'b1 : '0;
				end
			end
			S_EOUT: begin
				if (out_free) k_q <= k_q + 1'b1;
			end
			default: ;
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (st_q == S_ONE && out_free) begin
			sample_index <= 3'd0;
			is_center    <= 1'b0;
			weight       <= single_q ? W_MAX : 16'd0;
			is_largest   <= single_q;
			no_weights   <= !single_q;
			last_result  <= 1'b1;
		end else if (st_q == S_EOUT && out_free) begin
			sample_index <= ent_rd.idx;
			is_center    <= ent_rd.ctr;
			weight       <= ent_rd.w[15:0];
			is_largest   <= (k_q == bestk_q);
			no_weights   <= 1'b0;
			last_result  <= (k_q + 1'b1 == cnt_q);
		end
	end
endmodule

// ----- rtl/gbbw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gbbw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/gbbw_div.sv -----
// Restoring divider, one quotient bit per cycle.
module gbbw_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gbbw_pkg::div_req_t       req,
	output logic                     done,
	output logic [gbbw_pkg::Q_W-1:0] quot
);
	import gbbw_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STP_W-1:0]  cnt_q;
	logic [DV_W-1:0]   r_q;
	logic [DV_W-1:0]   dv_q;
	logic [NUM_W-1:0]  sh_q;
	logic [Q_W-1:0]    q_q;
	logic [DV_W:0]     t;
	logic              ge;
	logic [DV_W:0]     diff;

	assign t    = {r_q, sh_q[NUM_W-1]};
	assign ge   = t >= {1'b0, dv_q};
	assign diff = t - {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q  <= req.rem;
			sh_q <= req.bits;
			dv_q <= req.divisor;
			q_q  <= '0;
		end else if (busy_q) begin
			r_q  <= ge ? diff[DV_W-1:0] : t[DV_W-1:0];
			sh_q <= sh_q << 1;
			q_q  <= {q_q[Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = q_q;
endmodule

// ----- rtl/gbbw_chk.sv -----
// Port-level checker for the blend weight block, with its bind.
`include "gradient_band_blend_weights_macros.svh"

module gbbw_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        operation,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] weight,
	input logic        no_weights,
	input logic        last_result
);
	import gbbw_pkg::*;

	`GBBW_AST_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`GBBW_AST_NEXT(a_query_busy, in_valid && !in_stall && operation == OP_QUERY, in_stall)
	`GBBW_AST_NOW(a_empty_last, out_valid && no_weights, last_result && weight == 16'd0)
	`GBBW_AST_NOW(a_mid_not_empty, out_valid && !last_result, !no_weights)
endmodule

bind gradient_band_blend_weights gbbw_chk u_gbbw_chk (.*);

// ----- sim/tb_gradient_band_blend_weights.sv -----
// Self-checking testbench for the gradient band blend weight block.
module tb_gradient_band_blend_weights;
	timeunit 1ns;
	timeprecision 1ps;
	import gbbw_pkg::*;

	localparam int NSLOT = 8;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int DRAIN_CYCLES = 60;   // a write leaves no result; let it settle

	typedef struct packed {
		logic [2:0]  idx;
		logic        ctr;
		logic [15:0] w;
		logic        big;
		logic        none;
		logic        last;
	} blend_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = OP_WRITE;
	logic [2:0] sample_slot = 3'd0;
	logic signed [15:0] coord_x = '0;
	logic signed [15:0] coord_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] sample_index;
	logic is_center;
	logic [15:0] weight;
	logic is_largest;
	logic no_weights;
	logic last_result;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_SAMPLE_COUNT;
	logic [3:0] cfg_data = 4'd0;

	gradient_band_blend_weights u_top (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// predictor copy of the block's state
	longint pos_x [NSLOT];
	longint pos_y [NSLOT];
	int unsigned used_count = 1;
	bit center_on = 1'b0;
	blend_res_t weight_q [$];

	int errors = 0;
	int results_seen = 0;
	int queries_sent = 0;
	int writes_sent = 0;
	int cycles = 0;
	bit rx_quiet = 1'b0;   // receiver never stalls while set
	bit hold_go = 1'b0;    // request a long receiver hold-off

	// pair weight of anchor a against b seen from p, -1 on a zero-length edge
	function automatic longint edge_weight(longint ax, longint ay, longint bx, longint by,
			longint px, longint py);
		longint d1x, d1y, d2x, d2y, len, proj, num;
		d1x = ax - px;
		d1y = ay - py;
		d2x = ax - bx;
		d2y = ay - by;
		len = d2x * d2x + d2y * d2y;
		proj = d1x * d2x + d1y * d2y;
		if (len <= 0)
			return -1;
		num = len - proj;
		if (num <= 0)
			return 0;
		if (num >= len)
			return 65536;
		return (num * 65536) / len;
	endfunction

	// queue up the weights a query at (qx, qy) should produce
	function automatic void predict_blend(logic signed [15:0] qx, logic signed [15:0] qy);
		longint px, py, mw, pw, sum, best, nw;
		int n, cnt, bestk;
		logic [2:0] idx [NSLOT+1];
		logic ctr [NSLOT+1];
		longint wt [NSLOT+1];
		bit drop;
		blend_res_t r;
		px = qx;
		py = qy;
		n = (used_count > NSLOT) ? NSLOT : used_count;
		cnt = 0;
		sum = 0;
		best = 0;
		bestk = 0;
		if (n == 1 && !center_on) begin
			r = '{idx: 3'd0, ctr: 1'b0, w: W_MAX, big: 1'b1, none: 1'b0, last: 1'b1};
			weight_q.push_back(r);
			return;
		end
		for (int i = 0; i < n; i++) begin
			drop = 1'b0;
			mw = 65536;
			for (int j = 0; j < n; j++) begin
				pw = edge_weight(pos_x[i], pos_y[i], pos_x[j], pos_y[j], px, py);
				if (pw >= 0 && pw < mw)
					mw = pw;
			end
			if (center_on) begin
				pw = edge_weight(pos_x[i], pos_y[i], 0, 0, px, py);
				if (pw < 0)
					drop = 1'b1;
				else if (pw < mw)
					mw = pw;
			end
			if (!drop && mw > 0) begin
				idx[cnt] = i[2:0];
				ctr[cnt] = 1'b0;
				wt[cnt] = mw;
				sum += mw;
				cnt++;
			end
		end
		if (center_on) begin
			mw = 65536;
			for (int j = 0; j < n; j++) begin
				pw = edge_weight(0, 0, pos_x[j], pos_y[j], px, py);
				if (pw >= 0 && pw < mw)
					mw = pw;
			end
			if (mw > 0) begin
				idx[cnt] = 3'd0;
				ctr[cnt] = 1'b1;
				wt[cnt] = mw;
				sum += mw;
				cnt++;
			end
		end
		if (cnt == 0) begin
			r = '{idx: 3'd0, ctr: 1'b0, w: 16'd0, big: 1'b0, none: 1'b1, last: 1'b1};
			weight_q.push_back(r);
			return;
		end
		for (int k = 0; k < cnt; k++) begin
			nw = (wt[k] * 65536 + sum / 2) / sum;
			if (nw > 65535)
				nw = 65535;
			wt[k] = nw;
			if (k == 0 || nw > best) begin
				best = nw;
				bestk = k;
			end
		end
		for (int k = 0; k < cnt; k++) begin
			r.idx = idx[k];
			r.ctr = ctr[k];
			r.w = wt[k][15:0];
			r.big = (k == bestk);
			r.none = 1'b0;
			r.last = (k == cnt - 1);
			weight_q.push_back(r);
		end
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 2) != 0)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 150);
		return $urandom_range(1, 4);
	endfunction

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2, 3: return $urandom();
			default: return 16'($urandom_range(0, 4095)) - 16'd2048;
		endcase
	endfunction

	// Offer one request and return at the edge that takes it.
	// Called at a rising edge; the caller's gap keeps valid high when zero.
	task automatic send_request(logic op, logic [2:0] slot, logic [15:0] x, logic [15:0] y,
			int gap);
		bit ok;
		in_valid <= 1'b1;
		operation <= op;
		sample_slot <= slot;
		coord_x <= x;
		coord_y <= y;
		do begin
			@(negedge clk);
			ok = !in_stall;
			@(posedge clk);
		end while (!ok);
		if (op == OP_WRITE) begin
			pos_x[slot] = longint'($signed(x));
			pos_y[slot] = longint'($signed(y));
			writes_sent++;
		end else begin
			predict_blend(x, y);
			queries_sent++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// register write once all weights are out and the block has gone quiet
	task automatic set_reg(logic idx, logic [3:0] val);
		in_valid <= 1'b0;
		while (weight_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SAMPLE_COUNT)
			used_count = val;
		else
			center_on = val[0];
	endtask

	task automatic query_at(logic [15:0] x, logic [15:0] y);
		send_request(OP_QUERY, 3'($urandom()), x, y, pick_gap());
	endtask

	// reset state: one sample, no center, so full weight without touching slots
	task automatic test_single_sample();
		query_at(16'h0000, 16'h0000);
		query_at(16'h7FFF, 16'h8000);
	endtask

	// fill every slot so no query ever reads an unwritten one
	task automatic test_load_slots();
		logic [15:0] xs [NSLOT] = '{16'h8000, 16'h7FFF, 16'h0100, 16'hFF00,
			16'h0000, 16'h0200, 16'h0000, 16'h0155};
		logic [15:0] ys [NSLOT] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0100,
			16'h0180, 16'hFE00, 16'hFF00, 16'h0033};
		for (int s = 0; s < NSLOT; s++)
			send_request(OP_WRITE, s[2:0], xs[s], ys[s], pick_gap());
	endtask

	task automatic test_special_cases();
		// no samples in use: nothing positive, then the center alone
		set_reg(REG_SAMPLE_COUNT, 4'd0);
		query_at(16'h0040, 16'hFFC0);
		set_reg(REG_CENTER_EN, 1'b1);
		query_at(16'h0040, 16'hFFC0);
		// full set with center, query at the extremes
		set_reg(REG_SAMPLE_COUNT, 4'd8);
		query_at(16'h8000, 16'h8000);
		query_at(16'h7FFF, 16'h7FFF);
		// a sample sitting at the origin gets dropped with center on
		send_request(OP_WRITE, 3'd2, 16'h0000, 16'h0000, 0);
		query_at(16'h0010, 16'h0020);
		// count above the slot total saturates
		set_reg(REG_SAMPLE_COUNT, 4'd15);
		query_at(16'h0080, 16'h0000);
		// duplicate positions give a zero-length edge
		set_reg(REG_CENTER_EN, 1'b0);
		set_reg(REG_SAMPLE_COUNT, 4'd3);
		send_request(OP_WRITE, 3'd2, 16'h0100, 16'h0100, 0);
		send_request(OP_WRITE, 3'd1, 16'h0100, 16'h0100, 0);
		query_at(16'h0000, 16'h0000);
		query_at(16'h0100, 16'h0100);
		send_request(OP_WRITE, 3'd1, 16'hFF00, 16'h0000, 0);
		send_request(OP_WRITE, 3'd2, 16'h0000, 16'h0180, 0);
		query_at(16'h0000, 16'h0040);
	endtask

	// random settings, random writes and queries over all slots
	task automatic test_random_traffic();
		int items = 0;
		logic [3:0] cnt_val;
		while (items < 90) begin
			case ($urandom_range(0, 4))
				0: cnt_val = 4'($urandom_range(0, 15));
				1: cnt_val = 4'd8;
				2: cnt_val = 4'd2;
				default: cnt_val = 4'($urandom_range(1, 8));
			endcase
			set_reg(REG_SAMPLE_COUNT, cnt_val);
			set_reg(REG_CENTER_EN, 1'($urandom()));
			rx_quiet = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(4, 10)) begin
				if ($urandom_range(0, 2) == 0)
					send_request(OP_WRITE, 3'($urandom()), pick_coord(), pick_coord(),
						pick_gap());
				else
					query_at(pick_coord(), pick_coord());
				items++;
			end
		end
		rx_quiet = 1'b0;
	endtask

	// receiver holds off while queries keep coming, so the block backs up
	task automatic test_backpressure();
		set_reg(REG_SAMPLE_COUNT, 4'd8);
		set_reg(REG_CENTER_EN, 1'b1);
		hold_go = 1'b1;
		repeat (4)
			send_request(OP_QUERY, 3'd0, pick_coord(), pick_coord(), 0);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// receiver: random stall runs, plus the requested hold-off
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				// longer than one full query, so a result sits in the output
				hold_left = 6000;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (rx_quiet) begin
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
					: $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// checker: compare each accepted result with the oldest expected weight
	initial begin
		blend_res_t got, want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = '{idx: sample_index, ctr: is_center, w: weight, big: is_largest,
					none: no_weights, last: last_result};
				results_seen++;
				if (weight_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %p", got);
				end else begin
					want = weight_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p got %p", want, got);
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("** gradient_band_blend_weights: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_sample();
		test_load_slots();
		test_special_cases();
		test_backpressure();
		test_random_traffic();
		in_valid <= 1'b0;
		while (weight_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d queries and %0d slot writes, %0d weights checked",
			queries_sent, writes_sent, results_seen);
		$display("sample counts 0..15, center on and off, backpressure; %0d errors", errors);
		if (errors == 0 && weight_q.size() == 0)
			$display("** gradient_band_blend_weights: PASSED **");
		else
			$display("** gradient_band_blend_weights: FAILED **");
		$finish;
	end
endmodule
